@@ rtl/core/rlsd_pkg.sv @@
// rlsd_pkg: shared widths, codes and types of the run-length scanline channel decoder
// no dependencies
`timescale 1ns / 1ps

package rlsd_pkg;

	localparam int unsigned CODE_W     = 8;
	localparam int unsigned WIDTH_W    = 16;
	localparam int unsigned STRIDE_W   = 5;
	localparam int unsigned OFFSET_W   = 20;
	localparam int unsigned COUNT_W    = 8;
	localparam int unsigned POS_W      = 17;
	localparam int unsigned PROD_W     = COUNT_W + STRIDE_W;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [STRIDE_W-1:0] MAX_STRIDE = 5'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FILE_WIDTH    = 2'd0,
		CFG_IMAGE_WIDTH   = 2'd1,
		CFG_OUTPUT_STRIDE = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_REPEAT  = 2'd1,
		PH_LITERAL = 2'd2
	} phase_t;

	typedef struct packed {
		logic [CODE_W-1:0]   pixel_value;
		logic [WIDTH_W-1:0]  first_index;
		logic [OFFSET_W-1:0] byte_offset;
		logic [COUNT_W-1:0]  write_count;
		logic                line_end;
	} pix_t;

endpackage

@@ rtl/core/rlsd_code_if.sv @@
// rlsd_code_if: coded byte channel, one code word per handshake
// depends on rlsd_pkg
`timescale 1ns / 1ps

interface rlsd_code_if;
	import rlsd_pkg::*;

	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] code_byte;

	modport source (output valid, output code_byte, input ready);
	modport sink (input valid, input code_byte, output ready);
endinterface

@@ rtl/core/rlsd_pix_if.sv @@
// rlsd_pix_if: decoded pixel write channel, one result word per handshake
// depends on rlsd_pkg
`timescale 1ns / 1ps

interface rlsd_pix_if;
	import rlsd_pkg::*;

	logic                valid;
	logic                ready;
	logic [CODE_W-1:0]   pixel_value;
	logic [WIDTH_W-1:0]  first_index;
	logic [OFFSET_W-1:0] byte_offset;
	logic [COUNT_W-1:0]  write_count;
	logic                line_end;

	modport source (output valid, output pixel_value, output first_index,
		output byte_offset, output write_count, output line_end, input ready);
	modport sink (input valid, input pixel_value, input first_index,
		input byte_offset, input write_count, input line_end, output ready);
endinterface

@@ rtl/core/rlsd_cfg_if.sv @@
// rlsd_cfg_if: register write channel, index and data per word
// depends on rlsd_pkg
`timescale 1ns / 1ps

interface rlsd_cfg_if;
	import rlsd_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/rle_scanline_channel_decoder.sv @@
// rle_scanline_channel_decoder: one-channel run-length scanline decoder
// result: a value word's result is registered and shown in the cycle after acceptance; header words give none
// throughput: one code word per cycle when not stalled, set by the single result register and its skid-free
//   ready path (code.ready = result register empty or being taken)
// reset: arst_n clears line state, result valid and sets registers to file_width 1,
//   image_width 0, output_stride 1; cfg writes are always taken
`timescale 1ns / 1ps

module rle_scanline_channel_decoder (
	input logic     clk,
	input logic     arst_n,
	rlsd_cfg_if.sink  cfg,
	rlsd_code_if.sink code,
	rlsd_pix_if.source pix
);
	import rlsd_pkg::*;

	logic [WIDTH_W-1:0]  file_width_q;
	logic [WIDTH_W-1:0]  image_width_q;
	logic [STRIDE_W-1:0] stride_q;

	phase_t              phase_q, phase_d;
	logic [COUNT_W-1:0]  lit_left_q, lit_left_d;
	logic [COUNT_W-1:0]  rep_len_q, rep_len_d;
	logic [POS_W-1:0]    pos_q, pos_d;
	logic [OFFSET_W-1:0] off_q, off_d;

	pix_t res_q, res_d;
	logic res_valid_q;

	logic                accept;
	logic                emit;
	logic                finishing;
	logic [COUNT_W-1:0]  run_len;
	logic [COUNT_W-1:0]  lit_dec;
	logic [POS_W-1:0]    fw_eff;
	logic [STRIDE_W-1:0] stride_eff;
	logic [POS_W-1:0]    iw_ext;
	logic [POS_W-1:0]    room;
	logic [COUNT_W-1:0]  wc;
	logic [PROD_W-1:0]   prod;
	logic [POS_W-1:0]    pos_sum;
	logic [OFFSET_W-1:0] off_sum;
	logic                line_done;

	assign cfg.ready  = 1'b1;
	assign code.ready = !res_valid_q || pix.ready;
	assign accept     = code.valid && code.ready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_width_q  <= WIDTH_W'(1);
			image_width_q <= '0;
			stride_q      <= STRIDE_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_FILE_WIDTH:    file_width_q  <= cfg.data;
				CFG_IMAGE_WIDTH:   image_width_q <= cfg.data;
				CFG_OUTPUT_STRIDE: stride_q      <= cfg.data[STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	// run decode
	always_comb begin
		lit_dec   = lit_left_q - COUNT_W'(1);
		emit      = 1'b0;
		finishing = 1'b0;
		run_len   = '0;
		case (phase_q)
			PH_REPEAT: begin
				emit      = 1'b1;
				finishing = 1'b1;
				run_len   = rep_len_q;
			end
			PH_LITERAL: begin
				emit      = 1'b1;
				finishing = (lit_dec == '0);
				run_len   = COUNT_W'(1);
			end
			default: ;
		endcase
	end

	// clipping and position arithmetic
	always_comb begin
		fw_eff     = (file_width_q == '0) ? POS_W'(1) : {1'b0, file_width_q};
		stride_eff = (stride_q > MAX_STRIDE) ? MAX_STRIDE : stride_q;
		iw_ext     = {1'b0, image_width_q};
		room       = iw_ext - pos_q;
		if (pos_q >= iw_ext) begin
			wc = '0;
		end else if (room < POS_W'(run_len)) begin
			wc = room[COUNT_W-1:0];
		end else begin
			wc = run_len;
		end
		prod      = PROD_W'(wc) * PROD_W'(stride_eff);
		pos_sum   = pos_q + POS_W'(run_len);
		off_sum   = off_q + OFFSET_W'(prod);
		line_done = emit && finishing && (pos_sum >= fw_eff);
	end

	// next state
	always_comb begin
		phase_d    = phase_q;
		lit_left_d = lit_left_q;
		rep_len_d  = rep_len_q;
		pos_d      = pos_q;
		off_d      = off_q;
		if (accept) begin
			case (phase_q)
				PH_REPEAT: begin
					phase_d = PH_HEADER;
				end
				PH_LITERAL: begin
					lit_left_d = lit_dec;
					if (lit_dec == '0) begin
						phase_d = PH_HEADER;
					end
				end
				default: begin
					if (!code.code_byte[CODE_W-1]) begin
						rep_len_d = code.code_byte + COUNT_W'(1);
						phase_d   = PH_REPEAT;
					end else begin
						lit_left_d = ~code.code_byte + COUNT_W'(1);
						phase_d    = PH_LITERAL;
					end
				end
			endcase
			if (emit) begin
				pos_d = pos_sum;
				off_d = off_sum;
			end
			if (line_done) begin
				phase_d    = PH_HEADER;
				lit_left_d = '0;
				rep_len_d  = '0;
				pos_d      = '0;
				off_d      = '0;
			end
		end
	end

	// result word
	always_comb begin
		res_d.pixel_value = code.code_byte;
		res_d.first_index = pos_q[WIDTH_W-1:0];
		res_d.byte_offset = off_q;
		res_d.write_count = wc;
		res_d.line_end    = line_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			lit_left_q  <= '0;
			rep_len_q   <= '0;
			pos_q       <= '0;
			off_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			lit_left_q <= lit_left_d;
			rep_len_q  <= rep_len_d;
			pos_q      <= pos_d;
			off_q      <= off_d;
			if (accept && emit) begin
				res_valid_q <= 1'b1;
			end else if (pix.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			res_q <= res_d;
		end
	end

	assign pix.valid       = res_valid_q;
	assign pix.pixel_value = res_q.pixel_value;
	assign pix.first_index = res_q.first_index;
	assign pix.byte_offset = res_q.byte_offset;
	assign pix.write_count = res_q.write_count;
	assign pix.line_end    = res_q.line_end;

endmodule

@@ rtl/core/rlsd_checker.sv @@
// rlsd_checker: port-level assertions for rle_scanline_channel_decoder
// depends on rlsd_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps

module rlsd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          code_ready,
	input logic                          pix_valid,
	input logic                          pix_ready,
	input logic [rlsd_pkg::WIDTH_W-1:0]  pix_first_index,
	input logic [rlsd_pkg::OFFSET_W-1:0] pix_byte_offset,
	input logic [rlsd_pkg::COUNT_W-1:0]  pix_write_count,
	input logic                          pix_line_end
);
	import rlsd_pkg::*;

	// stalled result word keeps valid, index, offset and count
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid && $stable(pix_first_index)
			&& $stable(pix_byte_offset) && $stable(pix_write_count))
		else $error("stalled result word changed");

	// no new code word while a result is stuck
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |-> !code_ready)
		else $error("code taken while result stalled");

	// a run never writes more than 128 pixels
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid |-> pix_write_count <= COUNT_W'(128))
		else $error("write count above run limit");

	// a new line starts at pixel zero and offset zero
	a_line_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready && pix_line_end ##1 pix_valid && pix_ready
			|-> pix_first_index == '0 && pix_byte_offset == '0)
		else $error("line did not restart at zero");

endmodule

bind rle_scanline_channel_decoder rlsd_checker u_rlsd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.code_ready      (code.ready),
	.pix_valid       (pix.valid),
	.pix_ready       (pix.ready),
	.pix_first_index (pix.first_index),
	.pix_byte_offset (pix.byte_offset),
	.pix_write_count (pix.write_count),
	.pix_line_end    (pix.line_end)
);

@@ dv/testbench.sv @@
// testbench: self-checking bench for rle_scanline_channel_decoder
// drives code and register words, predicts pixel words in a scoreboard class
// depends on rlsd_pkg, rlsd_cfg_if, rlsd_code_if, rlsd_pix_if and the decoder
`timescale 1ns / 1ps

module testbench;
	import rlsd_pkg::*;

	localparam int ITEM_TOTAL  = 1850;
	localparam int CALM_ITEMS  = 150;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 64;

	class pixel_scoreboard;
		logic [WIDTH_W-1:0]  file_width;
		logic [WIDTH_W-1:0]  image_width;
		logic [STRIDE_W-1:0] stride;
		phase_t              code_phase;
		logic [7:0]          literal_left;
		logic [7:0]          repeat_len;
		logic [POS_W-1:0]    position;
		logic [OFFSET_W:0]   offset_accum;
		pix_t                expected_pixels[$];
		int                  mismatches;

		function new();
			file_width  = 16'd1;
			image_width = 16'd0;
			stride      = 5'd1;
			mismatches  = 0;
			clear_line();
		endfunction

		function void clear_line();
			code_phase   = PH_HEADER;
			literal_left = 8'd0;
			repeat_len   = 8'd0;
			position     = '0;
			offset_accum = '0;
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction

		function bit at_line_start();
			return code_phase == PH_HEADER && position == 0;
		endfunction

		function void write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				CFG_FILE_WIDTH:    file_width = value;
				CFG_IMAGE_WIDTH:   image_width = value;
				CFG_OUTPUT_STRIDE: stride = value[STRIDE_W-1:0];
				default: ;
			endcase
		endfunction

		// one value byte covering run pixels; clipped at image width
		function void emit_pixel(logic [7:0] value, int unsigned run, bit finishing);
			pix_t        p;
			int unsigned count;
			int unsigned fw;
			int unsigned st;
			count = 0;
			if (32'(position) < 32'(image_width)) begin
				count = 32'(image_width) - 32'(position);
				if (count > run)
					count = run;
			end
			fw = (file_width == 0) ? 32'd1 : 32'(file_width);
			st = (stride > MAX_STRIDE) ? 32'(MAX_STRIDE) : 32'(stride);
			p.pixel_value = value;
			p.first_index = position[WIDTH_W-1:0];
			p.byte_offset = offset_accum[OFFSET_W-1:0];
			p.write_count = count[COUNT_W-1:0];
			position      = 17'(position + run);
			offset_accum  = 21'(offset_accum + count * st);
			p.line_end    = finishing && (32'(position) >= fw);
			if (p.line_end)
				clear_line();
			expected_pixels.push_back(p);
		endfunction

		function void take_code_byte(logic [7:0] b);
			bit last;
			case (code_phase)
				PH_REPEAT: begin
					code_phase = PH_HEADER;
					emit_pixel(b, 32'(repeat_len), 1'b1);
				end
				PH_LITERAL: begin
					literal_left = literal_left - 8'd1;
					last = (literal_left == 8'd0);
					if (last)
						code_phase = PH_HEADER;
					emit_pixel(b, 1, last);
				end
				default: begin
					if (b < 8'h80) begin
						repeat_len = b + 8'd1;
						code_phase = PH_REPEAT;
					end else begin
						literal_left = 8'd0 - b;
						code_phase = PH_LITERAL;
					end
				end
			endcase
		endfunction

		function string describe(pix_t p);
			return $sformatf("value %02h index %0d offset %0d count %0d end %0b",
				p.pixel_value, p.first_index, p.byte_offset, p.write_count, p.line_end);
		endfunction

		function void flag(string what, pix_t want, pix_t got);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t %s", $time, what);
				$display("  expected %s", describe(want));
				$display("  got      %s", describe(got));
			end
		endfunction

		function void check_pixel_word(pix_t got);
			pix_t want;
			if (expected_pixels.size() == 0) begin
				flag("pixel word with nothing expected", '0, got);
				return;
			end
			want = expected_pixels.pop_front();
			if (got.pixel_value !== want.pixel_value || got.first_index !== want.first_index ||
				got.byte_offset !== want.byte_offset || got.write_count !== want.write_count ||
				got.line_end !== want.line_end)
				flag("pixel word mismatch", want, got);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rlsd_cfg_if  cfg_bus ();
	rlsd_code_if code_bus ();
	rlsd_pix_if  pix_bus ();

	rle_scanline_channel_decoder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.code(code_bus),
		.pix(pix_bus)
	);

	pixel_scoreboard sb = new();

	int items_sent   = 0;
	int code_gap_pct = 0;
	int pix_gap_pct  = 0;
	bit pix_hold_req = 1'b0;
	int quiet_cycles = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin : bus_monitor
		pix_t got;
		if (arst_n) begin
			if (pix_bus.valid && pix_bus.ready) begin
				got.pixel_value = pix_bus.pixel_value;
				got.first_index = pix_bus.first_index;
				got.byte_offset = pix_bus.byte_offset;
				got.write_count = pix_bus.write_count;
				got.line_end    = pix_bus.line_end;
				sb.check_pixel_word(got);
			end
			if (code_bus.valid && code_bus.ready)
				sb.take_code_byte(code_bus.code_byte);
			if (cfg_bus.valid && cfg_bus.ready)
				sb.write_register(cfg_idx_t'(cfg_bus.index), cfg_bus.data);
		end
	end

	always @(posedge clk) begin : watchdog
		if ((pix_bus.valid && pix_bus.ready) || (code_bus.valid && code_bus.ready) ||
			(cfg_bus.valid && cfg_bus.ready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("rle_scanline_channel_decoder regression: fail");
			$finish;
		end
	end

	initial begin : pixel_receiver
		pix_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (pix_hold_req) begin
				pix_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				pix_hold_req = 1'b0;
			end else if (pix_gap_pct != 0 && $urandom_range(99) < pix_gap_pct) begin
				pix_bus.ready <= 1'b0;
				repeat ($urandom_range(7, 1)) @(posedge clk);
			end else begin
				pix_bus.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_code(logic [7:0] b);
		if (code_gap_pct != 0 && $urandom_range(99) < code_gap_pct) begin
			code_bus.valid <= 1'b0;
			repeat ($urandom_range(7, 1)) @(posedge clk);
		end
		code_bus.valid     <= 1'b1;
		code_bus.code_byte <= b;
		do @(posedge clk); while (!code_bus.ready);
		items_sent++;
	endtask

	task automatic flush_pixels();
		code_bus.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_registers(logic [15:0] fw, logic [15:0] iw, logic [15:0] st);
		cfg_idx_t    idx[3];
		logic [15:0] val[3];
		idx = '{CFG_FILE_WIDTH, CFG_IMAGE_WIDTH, CFG_OUTPUT_STRIDE};
		val = '{fw, iw, st};
		for (int i = 0; i < 3; i++) begin
			cfg_bus.valid <= 1'b1;
			cfg_bus.index <= idx[i];
			cfg_bus.data  <= val[i];
			do @(posedge clk); while (!cfg_bus.ready);
		end
		cfg_bus.valid <= 1'b0;
		repeat (2) @(posedge clk);
	endtask

	task automatic load_random_registers();
		int unsigned fw;
		int unsigned iw;
		case ($urandom_range(7))
			0: fw = 0;
			1: fw = 1;
			2: fw = 65535;
			3: fw = $urandom_range(600, 100);
			default: fw = $urandom_range(48, 2);
		endcase
		case ($urandom_range(5))
			0: iw = 0;
			1: iw = 65535;
			2: iw = fw;
			default: iw = $urandom_range(fw + 16, 0);
		endcase
		if (iw > 65535)
			iw = 65535;
		load_registers(16'(fw), 16'(iw), {11'($urandom_range(2047)), 5'($urandom_range(31))});
	endtask

	// a header and its value words, or a single stray byte
	task automatic send_run(bit noise);
		int unsigned len;
		bit          literal;
		if (noise) begin
			send_code(8'($urandom_range(255)));
			return;
		end
		literal = 1'($urandom_range(1));
		case ($urandom_range(9))
			0: len = 128;
			1: len = $urandom_range(128, 1);
			default: len = $urandom_range(6, 1);
		endcase
		if (literal) begin
			send_code(8'(256 - len));
			repeat (len) send_code(8'($urandom_range(255)));
		end else begin
			send_code(8'(len - 1));
			send_code(8'($urandom_range(255)));
		end
	endtask

	task automatic align_line_start();
		load_registers(16'd1, 16'd0, 16'd1);
		while (!sb.at_line_start()) begin
			send_run(1'b0);
			flush_pixels();
		end
	endtask

	// full-width line: last literal lands on index 65535, clipped
	task automatic long_line();
		load_registers(16'hFFFF, 16'hFFFF, 16'd20);
		repeat (511) begin
			send_code(8'h7F);
			send_code(8'($urandom_range(255)));
		end
		send_code(8'h7D);
		send_code(8'($urandom_range(255)));
		send_code(8'hFE);
		send_code(8'($urandom_range(255)));
		send_code(8'($urandom_range(255)));
	endtask

	initial begin : stimulus
		int          phase_no;
		int unsigned start;
		int unsigned span;
		code_bus.valid     <= 1'b0;
		code_bus.code_byte <= 8'h00;
		cfg_bus.valid      <= 1'b0;
		cfg_bus.index      <= CFG_FILE_WIDTH;
		cfg_bus.data       <= 16'h0000;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset widths: every pixel clipped, line ends on the first run
		send_code(8'h00);
		send_code(8'hFF);
		flush_pixels();
		// zero file width, zero stride
		load_registers(16'd0, 16'hFFFF, 16'd0);
		send_code(8'h7F);
		send_code(8'h00);
		send_code(8'hFF);
		send_code(8'hA5);
		flush_pixels();
		// saturated stride
		load_registers(16'd300, 16'd200, 16'hFFFF);
		send_code(8'h7F);
		send_code(8'h55);
		send_code(8'hFD);
		send_code(8'h01);
		send_code(8'h80);
		send_code(8'hFE);
		flush_pixels();
		load_registers(16'd300, 16'd200, 16'd16);
		send_code(8'h7F);
		send_code(8'hAA);
		send_code(8'h7F);
		send_code(8'h33);
		flush_pixels();

		phase_no = 0;
		while (items_sent < ITEM_TOTAL - CALM_ITEMS) begin
			code_gap_pct = 25 * $urandom_range(2);
			pix_gap_pct  = 25 * $urandom_range(2);
			if (phase_no == 3) begin
				align_line_start();
				long_line();
			end else begin
				load_random_registers();
				if (phase_no == 1) begin
					pix_hold_req = 1'b1;
					code_gap_pct = 0;
				end
				start = items_sent;
				span  = $urandom_range(120, 30);
				while (items_sent - start < span)
					send_run($urandom_range(11) == 0);
			end
			flush_pixels();
			phase_no++;
		end

		code_gap_pct = 0;
		pix_gap_pct  = 0;
		load_random_registers();
		while (items_sent < ITEM_TOTAL)
			send_run(1'b0);
		flush_pixels();

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("rle_scanline_channel_decoder regression: pass");
		else
			$display("rle_scanline_channel_decoder regression: fail");
		$finish;
	end

endmodule
